@@ hdl/tte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tte_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int OWNER_BITS_DEF  = 8;
    localparam int MAX_REPORTS     = 16;
    localparam int IN_BITS         = 128;
    localparam int OUT_BITS        = 48;

    typedef enum logic [2:0] {
        REQ_ONCE   = 3'd0,
        REQ_REPEAT = 3'd1,
        REQ_FRAMES = 3'd2,
        REQ_CANCEL = 3'd3,
        REQ_QUERY  = 3'd4,
        REQ_CANOWN = 3'd5,
        REQ_TICK   = 3'd6,
        REQ_CLEAR  = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ONCE   = 2'd0,
        MODE_REPEAT = 2'd1,
        MODE_FRAMES = 2'd2
    } mode_t;
endpackage
`default_nettype wire

@@ hdl/timer_table_engine_unit.sv @@
// channel | dir | tdata (low bit up)                                  | tuser
// s_axis  | in  | req_type, now_ms, amount, timer_ref, owner_tag       | -
// m_axis  | out | status, result_id, is_active, fired, fired_owner     | -  (tlast = last)
// one request at a time; a slot walker visits one table entry per cycle unless a result is stalled
// schedule, cancel, query, cancel owner and clear: one scan over the table, then the result
// tick: an evaluation pass, a packing pass and a final state with the last result
// a stalled result holds the walker during the scan; rst_n clears valid bits and next id to one
`timescale 1ns / 1ps
`default_nettype none
module timer_table_engine_unit #(
    parameter int TABLE_DEPTH    = tte_pkg::TABLE_DEPTH_DEF,
    parameter int OWNER_TAG_BITS = tte_pkg::OWNER_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_type[2:0], now_ms[50:3], amount[82:51], timer_ref[114:83], owner_tag[122:115]
    input  wire logic [tte_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // status[1:0], result_id[33:2], is_active[34], fired[35], fired_owner[43:36]
    output logic [tte_pkg::OUT_BITS-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast
);
    import tte_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $clog2(MAX_REPORTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EMIT, S_PACK, S_DONE} state_t;

    logic [TABLE_DEPTH-1:0]    act_reg, used_reg;
    mode_t                     mode_mem     [TABLE_DEPTH];
    logic [31:0]               id_mem       [TABLE_DEPTH];
    logic [OWNER_TAG_BITS-1:0] own_mem      [TABLE_DEPTH];
    logic [48:0]               dl_mem       [TABLE_DEPTH];
    logic [31:0]               per_mem      [TABLE_DEPTH];
    logic [31:0]               fr_mem       [TABLE_DEPTH];

    state_t                    state_reg;
    logic [IW-1:0]             idx_reg;
    logic [CW-1:0]             wr_reg;
    logic                      found_reg;
    logic [RW-1:0]             nrep_reg;
    logic [31:0]               next_id_reg;
    req_t                      req_reg;
    logic [47:0]               now_reg;
    logic [31:0]               amt_reg, ref_reg;
    logic [OWNER_TAG_BITS-1:0] own_reg;
    logic                      ov_reg, ol_reg;
    logic [OUT_BITS-1:0]       od_reg;
    logic                      pend_reg;
    logic [43:0]               pend_data_reg;

    logic                      idx_end;
    logic                      live;
    logic [48:0]               dl_sum;
    logic [48:0]               dl_alt;
    logic                      due;
    logic                      fire;
    logic [OWNER_TAG_BITS-1:0] in_owner;

    assign idx_end  = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign live     = used_reg[idx_reg] && act_reg[idx_reg];
    assign dl_sum   = dl_mem[idx_reg] + 49'(per_mem[idx_reg]);
    assign dl_alt   = 49'(now_reg) + 49'(per_mem[idx_reg]);
    assign due      = 49'(now_reg) >= dl_mem[idx_reg];
    assign fire     = live && ((mode_mem[idx_reg] == MODE_FRAMES) ?
                      (fr_mem[idx_reg] == 32'd0) : due);
    assign in_owner = OWNER_TAG_BITS'(s_axis_tdata[122:115]);

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    function automatic logic [OUT_BITS-1:0] pack_out(status_t st, logic [31:0] id,
        logic a, logic f, logic [7:0] o);
        return {4'd0, o, f, a, id, st};
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && fire && !(ov_reg && !m_axis_tready)
            && req_reg == REQ_TICK && mode_mem[idx_reg] == MODE_REPEAT)
        begin
            dl_mem[idx_reg] <= (dl_sum <= 49'(now_reg)) ? dl_alt : dl_sum;
        end
        else if (state_reg == S_SCAN && live && !fire && req_reg == REQ_TICK
                 && mode_mem[idx_reg] == MODE_FRAMES && !(ov_reg && !m_axis_tready))
        begin
            fr_mem[idx_reg] <= fr_mem[idx_reg] - 32'd1;
        end
        else if (state_reg == S_PACK && used_reg[idx_reg] && act_reg[idx_reg]
                 && wr_reg[IW-1:0] != idx_reg)
        begin
            mode_mem[wr_reg[IW-1:0]] <= mode_mem[idx_reg];
            id_mem[wr_reg[IW-1:0]]   <= id_mem[idx_reg];
            own_mem[wr_reg[IW-1:0]]  <= own_mem[idx_reg];
            dl_mem[wr_reg[IW-1:0]]   <= dl_mem[idx_reg];
            per_mem[wr_reg[IW-1:0]]  <= per_mem[idx_reg];
            fr_mem[wr_reg[IW-1:0]]   <= fr_mem[idx_reg];
        end
        else if (state_reg == S_DONE && wr_reg != CW'(TABLE_DEPTH)
                 && (req_reg == REQ_ONCE || req_reg == REQ_REPEAT
                     || req_reg == REQ_FRAMES)
                 && !(req_reg == REQ_REPEAT && amt_reg == 32'd0) && !ov_reg)
        begin
            mode_mem[wr_reg[IW-1:0]] <= mode_t'(req_reg[1:0]);
            id_mem[wr_reg[IW-1:0]]   <= next_id_reg;
            own_mem[wr_reg[IW-1:0]]  <= own_reg;
            dl_mem[wr_reg[IW-1:0]]   <= (req_reg == REQ_FRAMES) ? 49'd0 :
                                        49'(now_reg) + 49'(amt_reg);
            per_mem[wr_reg[IW-1:0]]  <= (req_reg == REQ_REPEAT) ? amt_reg : 32'd0;
            fr_mem[wr_reg[IW-1:0]]   <= (req_reg == REQ_FRAMES) ? amt_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            found_reg     <= 1'b0;
            nrep_reg      <= '0;
            next_id_reg   <= 32'd1;
            ov_reg        <= 1'b0;
            ol_reg        <= 1'b0;
            pend_reg      <= 1'b0;
            req_reg       <= REQ_ONCE;
            now_reg       <= '0;
            amt_reg       <= '0;
            ref_reg       <= '0;
            own_reg       <= '0;
            od_reg        <= '0;
            pend_data_reg <= '0;
        end
        else
        begin
            if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        req_reg   <= req_t'(s_axis_tdata[2:0]);
                        now_reg   <= s_axis_tdata[50:3];
                        amt_reg   <= s_axis_tdata[82:51];
                        ref_reg   <= s_axis_tdata[114:83];
                        own_reg   <= in_owner;
                        idx_reg   <= '0;
                        wr_reg    <= '0;
                        found_reg <= 1'b0;
                        nrep_reg  <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!(ov_reg && !m_axis_tready))
                    begin
                        case (req_reg)
                            REQ_ONCE, REQ_REPEAT, REQ_FRAMES:
                            begin
                                if (used_reg[idx_reg])
                                    wr_reg <= wr_reg + CW'(1);
                            end
                            REQ_CANCEL:
                            begin
                                if (!found_reg && used_reg[idx_reg]
                                    && id_mem[idx_reg] == ref_reg && ref_reg != 32'd0)
                                begin
                                    found_reg        <= 1'b1;
                                    act_reg[idx_reg] <= 1'b0;
                                end
                            end
                            REQ_QUERY:
                            begin
                                if (!found_reg && used_reg[idx_reg]
                                    && id_mem[idx_reg] == ref_reg)
                                begin
                                    found_reg <= 1'b1;
                                    wr_reg    <= CW'(act_reg[idx_reg]);
                                end
                            end
                            REQ_CANOWN:
                            begin
                                if (live && own_mem[idx_reg] == own_reg)
                                    act_reg[idx_reg] <= 1'b0;
                            end
                            REQ_TICK:
                            begin
                                if (fire && mode_mem[idx_reg] != MODE_REPEAT)
                                    act_reg[idx_reg] <= 1'b0;
                                if (fire && nrep_reg != RW'(MAX_REPORTS))
                                begin
                                    if (pend_reg)
                                    begin
                                        ov_reg <= 1'b1;
                                        ol_reg <= 1'b0;
                                        od_reg <= {4'd0, pend_data_reg};
                                    end
                                    pend_reg      <= 1'b1;
                                    pend_data_reg <= 44'(pack_out(ST_OK, id_mem[idx_reg],
                                        1'b0, 1'b1, 8'(own_mem[idx_reg])));
                                    nrep_reg      <= nrep_reg + RW'(1);
                                end
                            end
                            default:
                            begin
                                act_reg  <= '0;
                                used_reg <= '0;
                            end
                        endcase
                        if (idx_end)
                        begin
                            idx_reg   <= '0;
                            state_reg <= (req_reg == REQ_TICK) ? S_PACK : S_DONE;
                            if (req_reg == REQ_TICK)
                                wr_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                end
                S_PACK:
                begin
                    if (used_reg[idx_reg] && act_reg[idx_reg])
                        wr_reg <= wr_reg + CW'(1);
                    if (idx_end)
                        state_reg <= S_DONE;
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                default:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        ol_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                        case (req_reg)
                            REQ_ONCE, REQ_REPEAT, REQ_FRAMES:
                            begin
                                if (req_reg == REQ_REPEAT && amt_reg == 32'd0)
                                    od_reg <= pack_out(ST_INVALID, 32'd0, 1'b0, 1'b0, 8'd0);
                                else if (wr_reg == CW'(TABLE_DEPTH))
                                    od_reg <= pack_out(ST_FULL, 32'd0, 1'b0, 1'b0, 8'd0);
                                else
                                begin
                                    od_reg <= pack_out(ST_OK, next_id_reg, 1'b0, 1'b0, 8'd0);
                                    used_reg[wr_reg[IW-1:0]] <= 1'b1;
                                    act_reg[wr_reg[IW-1:0]]  <= 1'b1;
                                    next_id_reg <= (next_id_reg == 32'hFFFF_FFFF) ? 32'd1 :
                                                   next_id_reg + 32'd1;
                                end
                            end
                            REQ_CANCEL:
                                od_reg <= pack_out((ref_reg == 32'd0) ? ST_INVALID : ST_OK,
                                    32'd0, 1'b0, 1'b0, 8'd0);
                            REQ_QUERY:
                                od_reg <= pack_out((ref_reg == 32'd0) ? ST_INVALID : ST_OK,
                                    32'd0, (ref_reg != 32'd0) && found_reg && wr_reg[0],
                                    1'b0, 8'd0);
                            REQ_TICK:
                            begin
                                for (int i = 0; i < TABLE_DEPTH; i++)
                                begin
                                    used_reg[i] <= (CW'(i) < wr_reg);
                                    act_reg[i]  <= (CW'(i) < wr_reg);
                                end
                                od_reg <= pend_reg ? {4'd0, pend_data_reg} :
                                          pack_out(ST_OK, 32'd0, 1'b0, 1'b0, 8'd0);
                            end
                            default:
                                od_reg <= pack_out(ST_OK, 32'd0, 1'b0, 1'b0, 8'd0);
                        endcase
                    end
                end
            endcase
            if (state_reg == S_PACK && used_reg[idx_reg] && act_reg[idx_reg]
                && wr_reg[IW-1:0] != idx_reg)
            begin
                used_reg[wr_reg[IW-1:0]] <= 1'b1;
                act_reg[wr_reg[IW-1:0]]  <= 1'b1;
            end
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 32'd0)
        else $error("next id zero");
    a_used_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((act_reg & ~used_reg) == '0))
        else $error("active slot not used");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ov_reg) |=> ov_reg && ol_reg)
        else $error("final result missing");
endmodule
`default_nettype wire

@@ tb/timer_table_engine_unit_tb.sv @@
`timescale 1ns / 1ps
module timer_table_engine_unit_tb;
    import tte_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        req_t        kind;
        logic [47:0] now;
        logic [31:0] amount;
        logic [31:0] ref_id;
        logic [7:0]  owner;
        bit          drain;
    } request_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] id;
        logic        act;
        logic        fired;
        logic [7:0]  fowner;
        logic        last;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic m_axis_tlast;

    request_t pending_reqs[$];
    report_t  expected_reports[$];
    request_t cur_req;
    bit       s_took = 1'b0;
    int       sent_cnt = 0;
    int       errors = 0;
    int       reports_seen = 0;
    int       fired_seen = 0;

    // timer table mirror
    bit          t_used[DEPTH];
    bit          t_act[DEPTH];
    mode_t       t_mode[DEPTH];
    logic [31:0] t_id[DEPTH];
    logic [7:0]  t_own[DEPTH];
    logic [48:0] t_dl[DEPTH];
    logic [31:0] t_per[DEPTH];
    logic [31:0] t_frames[DEPTH];
    logic [31:0] next_id = 32'd1;

    // stimulus generator bookkeeping
    logic [47:0] gen_now = '0;
    int          gen_sched = 0;

    timer_table_engine_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic report_t mk_report(logic [1:0] st, logic [31:0] id, logic act,
                                          logic fired, logic [7:0] fo, logic last);
        report_t r;
        r.st = st; r.id = id; r.act = act; r.fired = fired; r.fowner = fo; r.last = last;
        return r;
    endfunction

    function automatic void queue_report(report_t r);
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic void queue_request(request_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    task automatic predict_request(input request_t rq);
        int n;
        int w;
        int hit;
        bit fire;
        logic [63:0] d;
        n = 0;
        hit = -1;
        case (rq.kind)
            REQ_ONCE, REQ_REPEAT, REQ_FRAMES:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (t_used[i]) n++;
                if (rq.kind == REQ_REPEAT && rq.amount == 0)
                    queue_report(mk_report(ST_INVALID, 0, 0, 0, 0, 1));
                else if (n >= DEPTH)
                    queue_report(mk_report(ST_FULL, 0, 0, 0, 0, 1));
                else
                begin
                    t_used[n] = 1; t_act[n] = 1;
                    t_mode[n] = mode_t'(rq.kind[1:0]);
                    t_id[n] = next_id;
                    t_own[n] = rq.owner;
                    t_dl[n] = (rq.kind == REQ_FRAMES) ? 49'd0 : 49'(rq.now) + 49'(rq.amount);
                    t_per[n] = (rq.kind == REQ_REPEAT) ? rq.amount : 32'd0;
                    t_frames[n] = (rq.kind == REQ_FRAMES) ? rq.amount : 32'd0;
                    queue_report(mk_report(ST_OK, next_id, 0, 0, 0, 1));
                    next_id++;
                    if (next_id == 0) next_id = 1;
                end
            end
            REQ_CANCEL, REQ_QUERY:
            begin
                if (rq.ref_id == 0)
                    queue_report(mk_report(ST_INVALID, 0, 0, 0, 0, 1));
                else
                begin
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (t_used[i] && t_id[i] == rq.ref_id) hit = i;
                    if (rq.kind == REQ_CANCEL)
                    begin
                        if (hit >= 0) t_act[hit] = 0;
                        queue_report(mk_report(ST_OK, 0, 0, 0, 0, 1));
                    end
                    else
                        queue_report(
                            mk_report(ST_OK, 0, (hit >= 0) && t_act[hit], 0, 0, 1));
                end
            end
            REQ_CANOWN:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (t_used[i] && t_act[i] && t_own[i] == rq.owner) t_act[i] = 0;
                queue_report(mk_report(ST_OK, 0, 0, 0, 0, 1));
            end
            REQ_TICK:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    fire = 0;
                    if (t_used[i] && t_act[i])
                    begin
                        if (t_mode[i] == MODE_ONCE)
                        begin
                            if (64'(rq.now) >= 64'(t_dl[i])) begin fire = 1; t_act[i] = 0; end
                        end
                        else if (t_mode[i] == MODE_REPEAT)
                        begin
                            if (64'(rq.now) >= 64'(t_dl[i]))
                            begin
                                fire = 1;
                                d = 64'(t_dl[i]) + 64'(t_per[i]);
                                if (d <= 64'(rq.now)) d = 64'(rq.now) + 64'(t_per[i]);
                                t_dl[i] = d[48:0];
                            end
                        end
                        else if (t_frames[i] == 0)
                        begin
                            fire = 1; t_act[i] = 0;
                        end
                        else
                            t_frames[i]--;
                    end
                    if (fire && n < MAX_REPORTS)
                    begin
                        queue_report(mk_report(ST_OK, t_id[i], 0, 1, t_own[i], 0));
                        n++;
                    end
                end
                w = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (t_used[i] && t_act[i])
                    begin
                        t_used[w] = 1; t_act[w] = 1; t_mode[w] = t_mode[i];
                        t_id[w] = t_id[i]; t_own[w] = t_own[i]; t_dl[w] = t_dl[i];
                        t_per[w] = t_per[i]; t_frames[w] = t_frames[i];
                        w++;
                    end
                for (int i = w; i < DEPTH; i++) begin t_used[i] = 0; t_act[i] = 0; end
                if (n == 0)
                    queue_report(mk_report(ST_OK, 0, 0, 0, 0, 1));
                else
                    expected_reports[$].last = 1;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++) begin t_used[i] = 0; t_act[i] = 0; end
                queue_report(mk_report(ST_OK, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    function automatic request_t mk_req(req_t k, logic [47:0] now, logic [31:0] amt,
                                        logic [31:0] rid, logic [7:0] own);
        request_t rq;
        rq.kind = k; rq.now = now; rq.amount = amt; rq.ref_id = rid; rq.owner = own;
        rq.drain = 0;
        return rq;
    endfunction

    function automatic request_t drain_marker();
        request_t rq;
        rq = mk_req(REQ_CLEAR, 0, 0, 0, 0);
        rq.drain = 1;
        return rq;
    endfunction

    function automatic request_t random_req();
        request_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            rq = mk_req(req_t'($urandom_range(0, 7)), 48'({$urandom, $urandom}), $urandom,
                        $urandom, 8'($urandom_range(0, 255)));
            if (rq.kind <= REQ_FRAMES) gen_sched++;
            return rq;
        end
        rq = mk_req(REQ_TICK, gen_now, 0, 0, 8'($urandom_range(0, 3)));
        if (pick < 22)
        begin
            rq.kind = REQ_ONCE;
            rq.amount = 32'($urandom_range(0, 200));
        end
        else if (pick < 36)
        begin
            rq.kind = REQ_REPEAT;
            rq.amount = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 150));
        end
        else if (pick < 48)
        begin
            rq.kind = REQ_FRAMES;
            rq.amount = 32'($urandom_range(0, 4));
        end
        else if (pick < 56)
        begin
            rq.kind = REQ_CANCEL;
            rq.ref_id = ($urandom_range(0, 9) == 0) ? 32'd0 :
                        32'($urandom_range(1, gen_sched + 2));
        end
        else if (pick < 64)
        begin
            rq.kind = REQ_QUERY;
            rq.ref_id = ($urandom_range(0, 9) == 0) ? 32'd0 :
                        32'($urandom_range(1, gen_sched + 2));
        end
        else if (pick < 68)
            rq.kind = REQ_CANOWN;
        else if (pick < 70)
            rq.kind = REQ_CLEAR;
        else
            gen_now += 48'($urandom_range(0, 80));
        if (rq.kind <= REQ_FRAMES) gen_sched++;
        return rq;
    endfunction

    // driver
    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = (sent_cnt < 120) ? 32 : (sent_cnt < 240) ? 77 : 0;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_took)
            begin
                if (pending_reqs.size() > 0 && pending_reqs[0].drain
                    && expected_reports.size() == 0)
                    void'(pending_reqs.pop_front());
                if (pending_reqs.size() > 0 && !pending_reqs[0].drain
                    && $urandom_range(0, 99) >= idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {5'd0, cur_req.owner, cur_req.ref_id, cur_req.amount,
                                     cur_req.now, cur_req.kind};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            idle_pct = (sent_cnt < 120) ? 77 : (sent_cnt < 240) ? 32 : 0;
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        s_took <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_request(cur_req);
            sent_cnt <= sent_cnt + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = mk_report(m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[34],
                            m_axis_tdata[35], m_axis_tdata[43:36], m_axis_tlast);
            reports_seen++;
            if (got.fired) fired_seen++;
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer st=%0d id=%h act=%b fired=%b owner=%h last=%b",
                         $time, got.st, got.id, got.act, got.fired, got.fowner, got.last);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.st !== want.st || got.id !== want.id || got.act !== want.act
                    || got.fired !== want.fired || got.fowner !== want.fowner
                    || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected st=%0d id=%h act=%b fired=%b owner=%h last=%b",
                             $time, want.st, want.id, want.act, want.fired, want.fowner,
                             want.last);
                    $display("%0t:          actual   st=%0d id=%h act=%b fired=%b owner=%h last=%b",
                             $time, got.st, got.id, got.act, got.fired, got.fowner, got.last);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++) begin t_used[i] = 0; t_act[i] = 0; end
        queue_request(mk_req(REQ_ONCE, 0, 0, 0, 8'hff));
        queue_request(mk_req(REQ_REPEAT, 0, 0, 0, 1));
        queue_request(mk_req(REQ_REPEAT, 10, 5, 0, 1));
        queue_request(mk_req(REQ_FRAMES, 0, 0, 0, 2));
        queue_request(mk_req(REQ_FRAMES, 0, 1, 0, 3));
        queue_request(mk_req(REQ_QUERY, 0, 0, 2, 0));
        queue_request(mk_req(REQ_QUERY, 0, 0, 0, 0));
        queue_request(mk_req(REQ_CANCEL, 0, 0, 0, 0));
        queue_request(mk_req(REQ_CANCEL, 0, 0, 32'hffff_ffff, 0));
        queue_request(mk_req(REQ_QUERY, 0, 0, 12345, 0));
        queue_request(mk_req(REQ_TICK, 100, 0, 0, 0));
        queue_request(mk_req(REQ_CANCEL, 0, 0, 2, 0));
        queue_request(mk_req(REQ_QUERY, 0, 0, 2, 0));
        queue_request(mk_req(REQ_TICK, 100, 0, 0, 0));
        queue_request(mk_req(REQ_TICK, 48'hffff_ffff_ffff, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            queue_request(mk_req(REQ_ONCE, 48'hffff_ffff_ffff, 32'hffff_ffff, 0,
                                 (i % 2) ? 8'h5a : 8'ha5));
        queue_request(drain_marker());
        queue_request(mk_req(REQ_CANOWN, 0, 0, 0, 8'h5a));
        queue_request(mk_req(REQ_CLEAR, 0, 0, 0, 0));
        gen_sched = 20;
        for (int i = 0; i < 350; i++)
        begin
            if (i == 150) queue_request(drain_marker());
            queue_request(random_req());
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_reports.size() == 0);
        repeat (200) @(posedge clk);
        $display("requests sent: %0d, result transfers checked: %0d, timers fired: %0d",
                 sent_cnt, reports_seen, fired_seen);
        $display("stalls on both sides, full table, invalid args, ticks and clears exercised");
        if (errors == 0 && expected_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
